>>> rtl/retry_backoff_scheduler_unit_assert.svh
// Assertion macros used by the scheduler unit.
`ifndef RETRY_BACKOFF_SCHEDULER_UNIT_ASSERT_SVH
`define RETRY_BACKOFF_SCHEDULER_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define RBS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbs assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define RBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbs assertion failed");

`endif

>>> rtl/rbs_pkg.sv
package rbs_pkg;
  localparam int unsigned SlotsDefault = 16;
  localparam int unsigned TimeW = 32;
  localparam int unsigned DelayW = 24;
  localparam int unsigned MultW = 16;
  localparam int unsigned AttW = 8;

  localparam logic [2:0] ReqEnq  = 3'd0;
  localparam logic [2:0] ReqTick = 3'd1;
  localparam logic [2:0] ReqOut  = 3'd2;
  localparam logic [2:0] ReqStat = 3'd3;
  localparam logic [2:0] ReqCnt  = 3'd4;

  localparam logic [2:0] StUnknown   = 3'd0;
  localparam logic [2:0] StPending   = 3'd1;
  localparam logic [2:0] StFlight    = 3'd2;
  localparam logic [2:0] StDelivered = 3'd3;
  localparam logic [2:0] StFailed    = 3'd4;

  localparam logic [1:0] CfgBase = 2'd0;
  localparam logic [1:0] CfgMult = 2'd1;
  localparam logic [1:0] CfgMax  = 2'd2;
  localparam logic [1:0] CfgLim  = 2'd3;

  localparam logic [1:0] CntEnq = 2'd0;
  localparam logic [1:0] CntAtt = 2'd1;
  localparam logic [1:0] CntDel = 2'd2;
  localparam logic [1:0] CntFail = 2'd3;

  typedef struct packed {
    logic                start;
    logic [AttW-1:0]     attempt;
    logic [DelayW-1:0]   base;
    logic [MultW-1:0]    mult;
    logic [DelayW-1:0]   cap;
  } bo_req_t;
endpackage

>>> rtl/rbs_backoff.sv
// Iterative backoff delay: one truncating multiply per cycle.
module rbs_backoff import rbs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bo_req_t           req_i,
  output logic              done_o,
  output logic [DelayW-1:0] delay_o
);
  logic [AttW-1:0]          cnt_q, cnt_d;
  logic                     busy_q, busy_d;
  logic [DelayW-1:0]        d_q, d_d;
  logic [DelayW+MultW-1:0]  prod;
  logic [DelayW+MultW-9:0]  stepv;

  // d fits 24 bits: clamped when growing, shrinks otherwise
  assign prod  = d_q * req_i.mult;
  assign stepv = prod[DelayW+MultW-1:8];

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    d_d    = d_q;
    done_o = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.attempt;
      d_d    = req_i.base;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
        if (req_i.mult >= 16'd256 && stepv > {8'd0, req_i.cap}) begin
          d_d = req_i.cap;
        end else begin
          d_d = stepv[DelayW-1:0];
        end
      end
    end
  end

  assign delay_o = (d_q > req_i.cap) ? req_i.cap : d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q <= d_d;
  end
endmodule

>>> rtl/retry_backoff_scheduler_unit.sv
// Retry backoff scheduler.
// Each item passes SIdle, SRead and SOut; a tick that scans also goes through SScan and
// SDone, and a failed outcome that reschedules waits in SBack while the backoff unit
// works through the new attempt count (one multiply per cycle).
// Throughput: one item at a time; a stalled result beat holds the next item in SOut.
// Reset clears status, counters, time and flight state at once; slot memory is not.
module retry_backoff_scheduler_unit import rbs_pkg::*; #(
  parameter int unsigned SLOTS = SlotsDefault,
  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: req_type[2:0], slot_id[6:3], acked[7], counter_select[9:8]
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: send_valid[0], send_slot[4:1], send_attempt[12:5], slot_state[15:13],
  // counter_value[47:16], outstanding[52:48], rejected[53]
  output logic [55:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);
  localparam int unsigned PW = ($clog2(SLOTS + 1) > 5) ? $clog2(SLOTS + 1) : 5;

  typedef enum logic [5:0] {
    SIdle = 6'b000001, SRead = 6'b000010, SScan = 6'b000100,
    SBack = 6'b001000, SDone = 6'b010000, SOut = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // config
  logic [DelayW-1:0] base_q, max_q;
  logic [MultW-1:0]  mult_q;
  logic [AttW-1:0]   lim_q;

  // state
  logic [TimeW-1:0] time_q;
  logic [2:0]       status_q [SLOTS];
  logic             fv_q;
  logic [SW-1:0]    fs_q;
  logic [PW-1:0]    pend_q;
  logic [31:0]      cnt_q [4];

  // slot memory: {due, attempts}
  logic [TimeW+AttW-1:0] mem [SLOTS];
  logic [TimeW+AttW-1:0] rd_q;
  logic                  mem_we;
  logic [SW-1:0]         mem_wa, mem_ra;
  logic [TimeW+AttW-1:0] mem_wd;

  // item
  logic [2:0]  req_q;
  logic [3:0]  slot_q;
  logic        ack_q;
  logic [1:0]  sel_q;

  // scan
  logic [SW:0]      idx_q;   // address issued
  logic [SW-1:0]    cur_q;   // entry whose data is in rd_q
  logic             cvld_q;
  logic             found_q;
  logic [SW-1:0]    best_q;
  logic [TimeW-1:0] bage_q;
  logic [AttW-1:0]  batt_q;
  logic [TimeW-1:0] age;

  logic [55:0] res_q;   // result under construction
  logic [55:0] out_q;   // result beat on the master side
  logic        ov_q;

  bo_req_t           bo_req;
  logic              bo_done;
  logic [DelayW-1:0] bo_delay;
  logic [AttW-1:0]   next_att;

  rbs_backoff u_bo (.clk_i, .rst_ni, .req_i(bo_req), .done_o(bo_done), .delay_o(bo_delay));

  logic          slot_ok;
  logic [SW-1:0] slot_idx;
  assign slot_ok  = ({5'd0, slot_q} < 9'(SLOTS));
  assign slot_idx = SW'(slot_q);

  assign s_axis_tready = (state_q == SIdle);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = out_q;
  assign age      = time_q - rd_q[TimeW+AttW-1:AttW];
  assign next_att = rd_q[AttW-1:0] + 1'b1;

  always_comb begin
    state_d = state_q;
    mem_ra  = fs_q;
    case (state_q)
      SIdle: state_d = (s_axis_tvalid && s_axis_tready) ? SRead : SIdle;
      SRead: begin
        if (req_q == ReqTick && !fv_q) begin
          state_d = SScan;
          mem_ra  = '0;
        end else if (req_q == ReqOut && fv_q && !ack_q && (next_att < lim_q)) begin
          state_d = SBack;
        end else begin
          state_d = SOut;
        end
      end
      SScan: begin
        mem_ra = idx_q[SW-1:0];
        if (idx_q == (SW+1)'(SLOTS) && !cvld_q) state_d = SDone;
      end
      SBack: state_d = bo_done ? SOut : SBack;
      SDone: state_d = SOut;
      SOut:  state_d = (ov_q && !m_axis_tready) ? SOut : SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[mem_ra];
  end

  always_comb begin
    bo_req.start   = (state_q == SRead) && req_q == ReqOut && fv_q && !ack_q &&
                     (next_att < lim_q);
    bo_req.attempt = next_att;
    bo_req.base    = base_q;
    bo_req.mult    = mult_q;
    bo_req.cap     = max_q;
    mem_we = 1'b0;
    mem_wa = fs_q;
    mem_wd = '0;
    if (state_q == SRead && req_q == ReqEnq && slot_ok &&
        status_q[slot_idx] != StPending && status_q[slot_idx] != StFlight) begin
      mem_we = 1'b1;
      mem_wa = slot_idx;
      mem_wd = {time_q, {AttW{1'b0}}};
    end else if (state_q == SBack && bo_done) begin
      mem_we = 1'b1;
      mem_wd = {time_q + {8'd0, bo_delay}, next_att};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      base_q <= 24'd100; mult_q <= 16'd512; max_q <= 24'd10000; lim_q <= 8'd5;
      time_q <= '0; fv_q <= 1'b0; fs_q <= '0; pend_q <= '0;
      for (int i = 0; i < SLOTS; i++) status_q[i] <= StUnknown;
      for (int i = 0; i < 4; i++) cnt_q[i] <= '0;
      ov_q <= 1'b0; out_q <= '0; res_q <= '0;
      req_q <= '0; slot_q <= '0; ack_q <= 1'b0; sel_q <= '0;
      idx_q <= '0; cur_q <= '0; cvld_q <= 1'b0; found_q <= 1'b0;
      best_q <= '0; bage_q <= '0; batt_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgBase: base_q <= cfg_data_i;
          CfgMult: mult_q <= cfg_data_i[MultW-1:0];
          CfgMax:  max_q  <= cfg_data_i;
          CfgLim:  lim_q  <= cfg_data_i[AttW-1:0];
          default: ;
        endcase
      end
      // result register loads once the previous beat has left
      if (state_q == SOut && (!ov_q || m_axis_tready)) begin
        ov_q  <= 1'b1;
        out_q <= {res_q[55:53], pend_q[4:0], res_q[47:0]};
      end else if (ov_q && m_axis_tready) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        SIdle: if (s_axis_tvalid && s_axis_tready) begin
          req_q  <= s_axis_tdata[2:0];
          slot_q <= s_axis_tdata[6:3];
          ack_q  <= s_axis_tdata[7];
          sel_q  <= s_axis_tdata[9:8];
          res_q  <= '0;
        end
        SRead: begin
          case (req_q)
            ReqEnq: begin
              if (!slot_ok || status_q[slot_idx] == StPending ||
                  status_q[slot_idx] == StFlight) begin
                res_q[53] <= 1'b1;
              end else begin
                status_q[slot_idx] <= StPending;
                pend_q <= pend_q + 1'b1;
                cnt_q[CntEnq] <= cnt_q[CntEnq] + 1'b1;
              end
            end
            ReqTick: begin
              time_q <= time_q + 1'b1;
              idx_q <= (SW+1)'(1); cur_q <= '0; cvld_q <= 1'b1; found_q <= 1'b0;
            end
            ReqOut: begin
              if (!fv_q) begin
                res_q[53] <= 1'b1;
              end else begin
                fv_q <= 1'b0;
                cnt_q[CntAtt] <= cnt_q[CntAtt] + 1'b1;
                if (ack_q) begin
                  status_q[fs_q] <= StDelivered;
                  cnt_q[CntDel] <= cnt_q[CntDel] + 1'b1;
                  if (pend_q != 0) pend_q <= pend_q - 1'b1;
                end else if (next_att >= lim_q) begin
                  status_q[fs_q] <= StFailed;
                  cnt_q[CntFail] <= cnt_q[CntFail] + 1'b1;
                  if (pend_q != 0) pend_q <= pend_q - 1'b1;
                end
              end
            end
            ReqStat: if (slot_ok) res_q[15:13] <= status_q[slot_idx];
            ReqCnt: res_q[47:16] <= cnt_q[sel_q];
            default: ;
          endcase
        end
        SScan: begin
          if (cvld_q && status_q[cur_q] == StPending && !age[TimeW-1] &&
              (!found_q || age > bage_q)) begin
            found_q <= 1'b1; best_q <= cur_q; bage_q <= age; batt_q <= rd_q[AttW-1:0];
          end
          cur_q  <= idx_q[SW-1:0];
          cvld_q <= (idx_q != (SW+1)'(SLOTS));
          if (idx_q != (SW+1)'(SLOTS)) idx_q <= idx_q + 1'b1;
        end
        SBack: if (bo_done) begin
          status_q[fs_q] <= StPending;
        end
        SDone: if (found_q) begin
          status_q[best_q] <= StFlight;
          fv_q <= 1'b1; fs_q <= best_q;
          res_q[0] <= 1'b1;
          res_q[4:1] <= 4'(best_q);
          res_q[12:5] <= batt_q;
        end
        default: ;
      endcase
    end
  end

  `include "retry_backoff_scheduler_unit_assert.svh"

  `RBS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, ov_q && !m_axis_tready, ov_q && $stable(out_q))
  `RBS_ASSERT_NEXT(a_out_follows, clk_i, rst_ni, state_q == SOut, ov_q)
  `RBS_ASSERT_IMPL(a_pend_bound, clk_i, rst_ni, 1'b1, pend_q <= PW'(SLOTS))
endmodule
